// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by aabb_contact_generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// prop must never hold at a clock edge outside reset
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ===== design/acg_pkg.sv =====
// ----------------------------------------------------------------------------
// acg_pkg
// Types and codes for the box contact generator.
// ----------------------------------------------------------------------------
package acg_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TEST  = 2'd1;
  localparam logic [1:0] ACT_FRAME = 2'd2;

  // configuration register indexes
  localparam logic CFG_SOLID_MASK   = 1'b0;
  localparam logic CFG_TRIGGER_MASK = 1'b1;

  // normal axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // reset values of the masks
  localparam logic [7:0] SOLID_MASK_RST   = 8'h01;
  localparam logic [7:0] TRIGGER_MASK_RST = 8'h02;

  // one collider slot as kept in the store (signed Q16.16 corners)
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic [7:0]         flags;
    logic [15:0]        entity;
  } box_t;

endpackage

// ===== design/aabb_contact_generator.sv =====
// ----------------------------------------------------------------------------
// aabb_contact_generator
// Narrow-phase contact generation for axis-aligned boxes kept in a slot store.
// ----------------------------------------------------------------------------
// One word is handled at a time. A load, frame start, unused action or pair
// test with an index out of range goes straight to the result stage; a pair
// test passes through the registered read of the slot store (two copies, one
// per collider of the pair), a stage of per-axis corner differences, a stage
// of overlap and per-axis minimum, and the axis pick that writes the result
// register. The next word is accepted as soon as the result register is
// loaded, even while that result still waits to be taken. Slots have no reset
// value: a slot must be loaded before a pair test names it.
`include "assert_macros.svh"

module aabb_contact_generator #(
  parameter int NUM_SLOTS         = 256,
  parameter int MAX_CONTACT_SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  index_a_i,
  input  logic [7:0]  index_b_i,
  input  logic signed [31:0] min_x_i,
  input  logic signed [31:0] min_y_i,
  input  logic signed [31:0] min_z_i,
  input  logic signed [31:0] max_x_i,
  input  logic signed [31:0] max_y_i,
  input  logic signed [31:0] max_z_i,
  input  logic [7:0]  collider_flags_i,
  input  logic [15:0] entity_id_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        contact_o,
  output logic        dropped_o,
  output logic [15:0] entity_first_o,
  output logic [15:0] entity_second_o,
  output logic [1:0]  normal_axis_o,
  output logic        normal_negative_o,
  output logic [31:0] penetration_o,
  output logic        is_trigger_o
);

  localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_CONTACT_SLOTS + 1);
  localparam int BOX_W  = $bits(acg_pkg::box_t);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CONTACT_SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_FIN
  } state_e;

  state_e           state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       solid_mask_q, trigger_mask_q;
  logic             test_q, test_d;

  // result payload registers
  logic        contact_q, dropped_q, nneg_q, trigger_q;
  logic [15:0] ent_a_q, ent_b_q;
  logic [1:0]  axis_q;
  logic [31:0] pen_q;

  // ---- input handshake and slot addressing
  logic              in_fire;
  logic              ld_fire;
  logic [ADDR_W+7:0] ext_a, ext_b;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              a_in_range, b_in_range;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ld_fire    = in_fire && (action_i == acg_pkg::ACT_LOAD) && a_in_range;

  assign ext_a      = {{ADDR_W{1'b0}}, index_a_i};
  assign ext_b      = {{ADDR_W{1'b0}}, index_b_i};
  assign addr_a     = ext_a[ADDR_W-1:0];
  assign addr_b     = ext_b[ADDR_W-1:0];
  assign a_in_range = ({24'd0, index_a_i} < 32'(NUM_SLOTS));
  assign b_in_range = ({24'd0, index_b_i} < 32'(NUM_SLOTS));

  // ---- slot store: two copies, written together, read per collider
  acg_pkg::box_t wr_box;
  acg_pkg::box_t box_a, box_b;
  logic [BOX_W-1:0] rd_a, rd_b;

  always_comb begin
    wr_box.min_x  = min_x_i;
    wr_box.min_y  = min_y_i;
    wr_box.min_z  = min_z_i;
    wr_box.max_x  = max_x_i;
    wr_box.max_y  = max_y_i;
    wr_box.max_z  = max_z_i;
    wr_box.flags  = collider_flags_i;
    wr_box.entity = entity_id_i;
  end

  acg_ram #(
    .WIDTH (BOX_W),
    .DEPTH (NUM_SLOTS)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (ld_fire),
    .waddr_i (addr_a),
    .wdata_i (wr_box),
    .re_i    (in_fire),
    .raddr_i (addr_a),
    .rdata_o (rd_a)
  );

  acg_ram #(
    .WIDTH (BOX_W),
    .DEPTH (NUM_SLOTS)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (ld_fire),
    .waddr_i (addr_a),
    .wdata_i (wr_box),
    .re_i    (in_fire),
    .raddr_i (addr_b),
    .rdata_o (rd_b)
  );

  assign box_a = acg_pkg::box_t'(rd_a);
  assign box_b = acg_pkg::box_t'(rd_b);

  // ---- stage 1: per-axis differences, 33-bit exact
  logic signed [32:0] pos_d [3];
  logic signed [32:0] neg_d [3];
  logic signed [32:0] pos_q [3];
  logic signed [32:0] neg_q [3];

  always_comb begin
    pos_d[0] = {box_a.max_x[31], box_a.max_x} - {box_b.min_x[31], box_b.min_x};
    pos_d[1] = {box_a.max_y[31], box_a.max_y} - {box_b.min_y[31], box_b.min_y};
    pos_d[2] = {box_a.max_z[31], box_a.max_z} - {box_b.min_z[31], box_b.min_z};
    neg_d[0] = {box_b.max_x[31], box_b.max_x} - {box_a.min_x[31], box_a.min_x};
    neg_d[1] = {box_b.max_y[31], box_b.max_y} - {box_a.min_y[31], box_a.min_y};
    neg_d[2] = {box_b.max_z[31], box_b.max_z} - {box_a.min_z[31], box_a.min_z};
  end

  // ---- stage 2: overlap, qualification, per-axis minimum
  logic        overlap_d, overlap_q;
  logic        qual_d, qual_q;
  logic        trig_d, trig_q;
  logic [31:0] mn_d [3];
  logic [31:0] mn_q [3];
  logic [2:0]  nsel_d, nsel_q;
  logic [7:0]  qual_mask;

  assign qual_mask = solid_mask_q | trigger_mask_q;

  always_comb begin
    overlap_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      // touching counts: both differences non-negative
      if (pos_q[i][32] || neg_q[i][32]) begin
        overlap_d = 1'b0;
      end
      nsel_d[i] = !(pos_q[i] < neg_q[i]);
      mn_d[i]   = nsel_d[i] ? neg_q[i][31:0] : pos_q[i][31:0];
    end
    qual_d = ((box_a.flags & qual_mask) != 8'd0) && ((box_b.flags & qual_mask) != 8'd0);
    trig_d = ((box_a.flags | box_b.flags) & trigger_mask_q) != 8'd0;
  end

  // ---- stage 3: axis pick, contact count, result
  logic [1:0]  axis;
  logic        hit;
  logic        full;
  logic        out_load;

  always_comb begin
    if ((mn_q[0] <= mn_q[1]) && (mn_q[0] <= mn_q[2])) begin
      axis = acg_pkg::AXIS_X;
    end else if (mn_q[1] <= mn_q[2]) begin
      axis = acg_pkg::AXIS_Y;
    end else begin
      axis = acg_pkg::AXIS_Z;
    end
  end

  assign hit      = test_q && overlap_q && qual_q;
  assign full     = (cnt_q >= CNT_MAX);
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // ---- sequencing and counters
  always_comb begin
    state_d     = state_q;
    test_d      = test_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (action_i == acg_pkg::ACT_FRAME) begin
            cnt_d = '0;
          end
          if ((action_i == acg_pkg::ACT_TEST) && a_in_range && b_in_range) begin
            test_d  = 1'b1;
            state_d = ST_READ;
          end else begin
            test_d  = 1'b0;
            state_d = ST_FIN;
          end
        end
      end
      ST_READ: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (hit && !full) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, masks and the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      test_q         <= 1'b0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
      solid_mask_q   <= acg_pkg::SOLID_MASK_RST;
      trigger_mask_q <= acg_pkg::TRIGGER_MASK_RST;
      contact_q      <= 1'b0;
      dropped_q      <= 1'b0;
      ent_a_q        <= '0;
      ent_b_q        <= '0;
      axis_q         <= acg_pkg::AXIS_X;
      nneg_q         <= 1'b0;
      pen_q          <= '0;
      trigger_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      test_q      <= test_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          acg_pkg::CFG_SOLID_MASK:   solid_mask_q   <= cfg_data_i;
          acg_pkg::CFG_TRIGGER_MASK: trigger_mask_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        if (hit) begin
          contact_q <= !full;
          dropped_q <= full;
          ent_a_q   <= box_a.entity;
          ent_b_q   <= box_b.entity;
          axis_q    <= axis;
          nneg_q    <= nsel_q[axis];
          pen_q     <= mn_q[axis];
          trigger_q <= trig_q;
        end else begin
          contact_q <= 1'b0;
          dropped_q <= 1'b0;
          ent_a_q   <= '0;
          ent_b_q   <= '0;
          axis_q    <= acg_pkg::AXIS_X;
          nneg_q    <= 1'b0;
          pen_q     <= '0;
          trigger_q <= 1'b0;
        end
      end
    end
  end

  // ---- datapath pipeline registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      pos_q <= pos_d;
      neg_q <= neg_d;
    end
    if (state_q == ST_DIFF) begin
      overlap_q <= overlap_d;
      qual_q    <= qual_d;
      trig_q    <= trig_d;
      mn_q      <= mn_d;
      nsel_q    <= nsel_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign contact_o         = contact_q;
  assign dropped_o         = dropped_q;
  assign entity_first_o    = ent_a_q;
  assign entity_second_o   = ent_b_q;
  assign normal_axis_o     = axis_q;
  assign normal_negative_o = nneg_q;
  assign penetration_o     = pen_q;
  assign is_trigger_o      = trigger_q;

  // ---- checks
  logic miss_word;
  logic miss_zero;

  assign miss_word = out_valid_o && !contact_o && !dropped_o;
  assign miss_zero = (penetration_o == 32'd0) && (entity_first_o == 16'd0) &&
                     (entity_second_o == 16'd0) && !normal_negative_o && !is_trigger_o;

  `ASSERT_NEVER(a_contact_and_drop, out_valid_o && contact_o && dropped_o, "both flags set")
  `ASSERT_NEVER(a_miss_all_zero, miss_word && !miss_zero, "non-contact result carries data")
  `ASSERT_NEVER(a_write_busy, ld_fire && (state_q != ST_IDLE), "store written while busy")
  `ASSERT_HOLDS(a_count_bound, cnt_q <= CNT_MAX, "contact count above limit")

endmodule

// ===== design/acg_ram.sv =====
// ----------------------------------------------------------------------------
// acg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/aabb_contact_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_contact_generator_tb
// Self-checking bench for the box contact generator. Slots are loaded and
// pair tests streamed over the valid/ready word channel under random gaps
// and result stalls; a scoreboard predicts every result word from its own
// copy of the slot store, masks and contact count, and checks each result
// word field by field in order.
// ----------------------------------------------------------------------------
module aabb_contact_generator_tb;

  localparam int NUM_SLOTS     = 256;
  localparam int CONTACT_LIMIT = 1024;

  // action 3 is unused by the block and must produce an all-zero result
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Q16.16 constants for the directed boxes
  localparam logic signed [31:0] ONE     = 32'sh0001_0000;
  localparam logic signed [31:0] HALF    = 32'sh0000_8000;
  localparam logic signed [31:0] THREE_Q = 32'sh0000_C000;
  localparam logic signed [31:0] FAR_LO  = 32'sh0010_0000;
  localparam logic signed [31:0] FAR_HI  = 32'sh0020_0000;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]    action;
    logic [7:0]    index_a;
    logic [7:0]    index_b;
    acg_pkg::box_t box;
  } cmd_t;

  typedef struct packed {
    logic        contact;
    logic        dropped;
    logic [15:0] entity_first;
    logic [15:0] entity_second;
    logic [1:0]  normal_axis;
    logic        normal_negative;
    logic [31:0] penetration;
    logic        is_trigger;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [7:0]  index_a_i;
  logic [7:0]  index_b_i;
  logic signed [31:0] min_x_i;
  logic signed [31:0] min_y_i;
  logic signed [31:0] min_z_i;
  logic signed [31:0] max_x_i;
  logic signed [31:0] max_y_i;
  logic signed [31:0] max_z_i;
  logic [7:0]  collider_flags_i;
  logic [15:0] entity_id_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        contact_o;
  logic        dropped_o;
  logic [15:0] entity_first_o;
  logic [15:0] entity_second_o;
  logic [1:0]  normal_axis_o;
  logic        normal_negative_o;
  logic [31:0] penetration_o;
  logic        is_trigger_o;

  aabb_contact_generator #(
    .NUM_SLOTS         (NUM_SLOTS),
    .MAX_CONTACT_SLOTS (CONTACT_LIMIT)
  ) dut (.*);

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Contact predictor and result checker
  // --------------------------------------------------------------------------
  class contact_scoreboard;
    acg_pkg::box_t slots[NUM_SLOTS];
    int unsigned   contact_count;
    logic [7:0]    solid;
    logic [7:0]    trigger;
    result_t       expq[$];
    int            errors;
    int            dropped_seen;
    int            results_seen;

    function new();
      contact_count = 0;
      solid         = acg_pkg::SOLID_MASK_RST;
      trigger       = acg_pkg::TRIGGER_MASK_RST;
      errors        = 0;
      dropped_seen  = 0;
      results_seen  = 0;
    endfunction

    function longint corner_lo(acg_pkg::box_t b, int k);
      case (k)
        0:       return longint'($signed(b.min_x));
        1:       return longint'($signed(b.min_y));
        default: return longint'($signed(b.min_z));
      endcase
    endfunction

    function longint corner_hi(acg_pkg::box_t b, int k);
      case (k)
        0:       return longint'($signed(b.max_x));
        1:       return longint'($signed(b.max_y));
        default: return longint'($signed(b.max_z));
      endcase
    endfunction

    // predict the result word for one accepted input word
    function void note_word(cmd_t w);
      result_t       r;
      acg_pkg::box_t a;
      acg_pkg::box_t b;
      longint        pos[3];
      longint        neg[3];
      longint        mn[3];
      logic [7:0]    qual;
      bit            hit;
      int            k;
      int            ax;
      r = '0;
      case (w.action)
        acg_pkg::ACT_LOAD:  slots[w.index_a] = w.box;
        acg_pkg::ACT_FRAME: contact_count = 0;
        acg_pkg::ACT_TEST: begin
          a    = slots[w.index_a];
          b    = slots[w.index_b];
          qual = solid | trigger;
          hit  = ((a.flags & qual) != 0) && ((b.flags & qual) != 0);
          // negative side depth means a gap on that axis; zero is touching
          for (k = 0; k < 3; k++) begin
            pos[k] = corner_hi(a, k) - corner_lo(b, k);
            neg[k] = corner_hi(b, k) - corner_lo(a, k);
            if (pos[k] < 0 || neg[k] < 0) hit = 0;
            mn[k] = (pos[k] < neg[k]) ? pos[k] : neg[k];
          end
          if (hit) begin
            // least penetration, ties to x then y
            if (mn[0] <= mn[1] && mn[0] <= mn[2]) begin
              ax = 0;
              r.normal_axis = acg_pkg::AXIS_X;
            end else if (mn[1] <= mn[2]) begin
              ax = 1;
              r.normal_axis = acg_pkg::AXIS_Y;
            end else begin
              ax = 2;
              r.normal_axis = acg_pkg::AXIS_Z;
            end
            if (contact_count < CONTACT_LIMIT) begin
              contact_count++;
              r.contact = 1'b1;
            end else begin
              r.dropped = 1'b1;
              dropped_seen++;
            end
            r.entity_first    = a.entity;
            r.entity_second   = b.entity;
            r.normal_negative = !(pos[ax] < neg[ax]);
            r.penetration     = 32'(mn[ax]);
            r.is_trigger      = (((a.flags | b.flags) & trigger) != 0);
          end
        end
        default: ;
      endcase
      expq.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100)
        $display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
    endtask

    // compare one accepted result word with the oldest prediction
    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (expq.size() == 0) begin
        report("result word with no prediction pending");
        return;
      end
      want = expq.pop_front();
      if (got.contact !== want.contact)
        report($sformatf("contact %b want %b", got.contact, want.contact));
      if (got.dropped !== want.dropped)
        report($sformatf("dropped %b want %b", got.dropped, want.dropped));
      if (got.entity_first !== want.entity_first)
        report($sformatf("entity_first %h want %h", got.entity_first, want.entity_first));
      if (got.entity_second !== want.entity_second)
        report($sformatf("entity_second %h want %h", got.entity_second, want.entity_second));
      if (got.normal_axis !== want.normal_axis)
        report($sformatf("normal_axis %0d want %0d", got.normal_axis, want.normal_axis));
      if (got.normal_negative !== want.normal_negative)
        report($sformatf("normal_negative %b want %b", got.normal_negative,
                         want.normal_negative));
      if (got.penetration !== want.penetration)
        report($sformatf("penetration %h want %h", got.penetration, want.penetration));
      if (got.is_trigger !== want.is_trigger)
        report($sformatf("is_trigger %b want %b", got.is_trigger, want.is_trigger));
    endtask
  endclass

  contact_scoreboard sb = new();

  bit         calm;
  bit         hold_done;
  bit         written[NUM_SLOTS];
  logic [7:0] written_q[$];
  bit         is_hot[NUM_SLOTS];
  logic [7:0] hot_q[$];

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic cmd_t junk_word(logic [1:0] act);
    cmd_t w;
    w.action  = act;
    w.index_a = 8'($urandom);
    w.index_b = 8'($urandom);
    w.box     = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 24'($urandom)};
    return w;
  endfunction

  function automatic cmd_t pair_word(logic [7:0] a, logic [7:0] b);
    cmd_t w;
    w         = junk_word(acg_pkg::ACT_TEST);
    w.index_a = a;
    w.index_b = b;
    return w;
  endfunction

  function automatic cmd_t box_word(logic [7:0] slot,
                                    logic signed [31:0] lx, ly, lz, hx, hy, hz,
                                    logic [7:0] flags, logic [15:0] ent);
    cmd_t w;
    w            = junk_word(acg_pkg::ACT_LOAD);
    w.index_a    = slot;
    w.box.min_x  = lx;
    w.box.min_y  = ly;
    w.box.min_z  = lz;
    w.box.max_x  = hx;
    w.box.max_y  = hy;
    w.box.max_z  = hz;
    w.box.flags  = flags;
    w.box.entity = ent;
    return w;
  endfunction

  // clean boxes straddle the origin, so any two of them overlap
  function automatic cmd_t load_word(logic [7:0] slot, bit clean);
    cmd_t               w;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [7:0]         qual;
    int                 k;
    int                 sel;
    w         = junk_word(acg_pkg::ACT_LOAD);
    w.index_a = slot;
    for (k = 0; k < 3; k++) begin
      sel = clean ? 9 : $urandom_range(0, 9);
      case (sel)
        0: begin
          lo = $urandom;
          hi = $urandom;
        end
        1: begin
          lo = Q_MIN;
          hi = Q_MAX;
        end
        2, 3: begin
          lo = $urandom_range(0, 7) << 16;
          hi = lo + ($urandom_range(0, 3) << 16);
        end
        default: begin
          lo = -($urandom_range(0, 5) << 16) - $urandom_range(0, 65535);
          hi = ($urandom_range(0, 5) << 16) + $urandom_range(0, 65535);
        end
      endcase
      case (k)
        0: begin
          w.box.min_x = lo;
          w.box.max_x = hi;
        end
        1: begin
          w.box.min_y = lo;
          w.box.max_y = hi;
        end
        default: begin
          w.box.min_z = lo;
          w.box.max_z = hi;
        end
      endcase
    end
    // most colliders get a qualifying flag bit
    qual = sb.solid | sb.trigger;
    if (qual != 0 && (clean || $urandom_range(0, 3) != 0)) begin
      do k = $urandom_range(0, 7); while (!qual[k]);
      w.box.flags[k] = 1'b1;
    end
    return w;
  endfunction

  function automatic logic [7:0] pick_written();
    return written_q[$urandom_range(0, written_q.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_hot();
    return hot_q[$urandom_range(0, hot_q.size() - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_word(cmd_t w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= w.action;
    index_a_i        <= w.index_a;
    index_b_i        <= w.index_b;
    min_x_i          <= w.box.min_x;
    min_y_i          <= w.box.min_y;
    min_z_i          <= w.box.min_z;
    max_x_i          <= w.box.max_x;
    max_y_i          <= w.box.max_y;
    max_z_i          <= w.box.max_z;
    collider_flags_i <= w.box.flags;
    entity_id_i      <= w.box.entity;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    if (w.action == acg_pkg::ACT_LOAD && !written[w.index_a]) begin
      written[w.index_a] = 1'b1;
      written_q.push_back(w.index_a);
    end
  endtask

  // drop valid and wait for every predicted word to drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write_masks(logic [7:0] solid, logic [7:0] trigger);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= acg_pkg::CFG_SOLID_MASK;
    cfg_data_i <= solid;
    @(posedge clk_i);
    cfg_idx_i  <= acg_pkg::CFG_TRIGGER_MASK;
    cfg_data_i <= trigger;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.solid   = solid;
    sb.trigger = trigger;
  endtask

  // general mix: loads, pair tests, frame starts and the unused action
  task automatic random_item();
    int         r;
    logic [7:0] a;
    r = $urandom_range(0, 99);
    a = pick_written();
    if (r < 25)
      send_word(load_word(8'($urandom), 1'($urandom_range(0, 1))));
    else if (r < 88)
      send_word(pair_word(a, ($urandom_range(0, 4) == 0) ? a : pick_written()));
    else if (r < 94)
      send_word(junk_word(acg_pkg::ACT_FRAME));
    else
      send_word(junk_word(ACT_UNUSED));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls plus one long hold-off to back up the block
  // --------------------------------------------------------------------------
  initial begin
    int      stall_left;
    result_t got;
    stall_left = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.contact         = contact_o;
        got.dropped         = dropped_o;
        got.entity_first    = entity_first_o;
        got.entity_second   = entity_second_o;
        got.normal_axis     = normal_axis_o;
        got.normal_negative = normal_negative_o;
        got.penetration     = penetration_o;
        got.is_trigger      = is_trigger_o;
        sb.check_result(got);
      end
      if (!hold_done && sb.results_seen >= 200) begin
        hold_done  = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         n;
    int         r;
    logic [7:0] s;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= acg_pkg::CFG_SOLID_MASK;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    action_i         <= acg_pkg::ACT_LOAD;
    index_a_i        <= '0;
    index_b_i        <= '0;
    min_x_i          <= '0;
    min_y_i          <= '0;
    min_z_i          <= '0;
    max_x_i          <= '0;
    max_y_i          <= '0;
    max_z_i          <= '0;
    collider_flags_i <= '0;
    entity_id_i      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed boxes under the reset masks
    send_word(box_word(8'd0, 0, 0, 0, ONE, ONE, ONE, 8'h01, 16'h0000));
    send_word(box_word(8'd255, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 8'h02, 16'hFFFF));
    // touches slot 0 at one corner, zero depth on every axis
    send_word(box_word(8'd1, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 8'h03, 16'h1111));
    send_word(box_word(8'd2, 0, 0, 0, ONE, ONE, ONE, 8'h01, 16'h2222));
    // degenerate box, min above max
    send_word(box_word(8'd3, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, 8'h01, 16'h3333));
    // no solid or trigger flag bit
    send_word(box_word(8'd4, 0, 0, 0, ONE, ONE, ONE, 8'hFC, 16'h4444));
    send_word(box_word(8'd5, FAR_LO, FAR_LO, FAR_LO, FAR_HI, FAR_HI, FAR_HI, 8'h01,
                       16'h5555));
    // y and z tie below x
    send_word(box_word(8'd6, 0, HALF, HALF, ONE, ONE, ONE, 8'h01, 16'h6666));
    send_word(box_word(8'd7, 0, 0, THREE_Q, ONE, ONE, ONE, 8'h01, 16'h7777));

    send_word(pair_word(8'd0, 8'd1));
    send_word(pair_word(8'd1, 8'd0));
    send_word(pair_word(8'd0, 8'd2));
    send_word(pair_word(8'd0, 8'd255));
    send_word(pair_word(8'd255, 8'd255));
    send_word(pair_word(8'd1, 8'd255));
    send_word(pair_word(8'd0, 8'd3));
    send_word(pair_word(8'd0, 8'd4));
    send_word(pair_word(8'd0, 8'd5));
    send_word(pair_word(8'd0, 8'd6));
    send_word(pair_word(8'd0, 8'd7));
    send_word(junk_word(acg_pkg::ACT_FRAME));
    send_word(junk_word(ACT_UNUSED));

    // every flag bit solid, no triggers
    settle();
    cfg_write_masks(8'hFF, 8'h00);
    repeat (300) random_item();

    // nothing qualifies
    settle();
    cfg_write_masks(8'h00, 8'h00);
    repeat (60) random_item();

    // long frame over overlapping colliders until the contact limit overflows
    settle();
    cfg_write_masks(8'h10, 8'h80);
    send_word(junk_word(acg_pkg::ACT_FRAME));
    repeat (12) begin
      do s = 8'($urandom); while (is_hot[s]);
      is_hot[s] = 1'b1;
      hot_q.push_back(s);
      send_word(load_word(s, 1'b1));
    end
    while (sb.dropped_seen < 40) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        send_word(pair_word(pick_hot(), pick_hot()));
      end else if (r < 91) begin
        send_word(pair_word(pick_written(), pick_written()));
      end else if (r < 97) begin
        s = 8'($urandom);
        if (!is_hot[s] && $urandom_range(0, 1) == 0) begin
          is_hot[s] = 1'b1;
          hot_q.push_back(s);
        end
        send_word(load_word(s, is_hot[s]));
      end else begin
        send_word(junk_word(ACT_UNUSED));
      end
    end
    // a new frame brings contacts back
    send_word(junk_word(acg_pkg::ACT_FRAME));
    repeat (10) send_word(pair_word(pick_hot(), pick_hot()));

    // every bit a trigger, no solids; the tail runs with no idling
    settle();
    cfg_write_masks(8'h00, 8'hFF);
    for (n = 0; n < 200; n++) begin
      if (n == 50) calm = 1'b1;
      random_item();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("aabb_contact_generator test passed");
    else
      $display("aabb_contact_generator test failed");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("aabb_contact_generator test failed");
    $finish;
  end

endmodule
